>>> sv/packed_sample_unpacker_core_defines.svh
// ----------------------------------------------------------------------------
// Packed sample unpacker assertion macros
// Clocked property checks, compiled out when ASSERT_OFF is set.
// ----------------------------------------------------------------------------
`ifndef PACKED_SAMPLE_UNPACKER_CORE_DEFINES_SVH
`define PACKED_SAMPLE_UNPACKER_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
// check while out of reset
`define PSU_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("psu assertion failed");
// check at every edge, reset included
`define PSU_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("psu assertion failed");
`else
`define PSU_ASSERT(lbl, clk, rst_n, prop)
`define PSU_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

>>> sv/psu_pkg.sv
// ----------------------------------------------------------------------------
// psu_pkg
// Shared types and constants of the packed sample unpacker.
// ----------------------------------------------------------------------------
`default_nettype none

package psu_pkg;

    localparam int MAX_ROW_SAMPLES_DEF = 32768;
    localparam int QUEUE_DEPTH         = 2;

    localparam int WORD_W     = 32;
    localparam int CODE_W     = 16;
    localparam int ROW_W      = 16;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_FORMAT = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PACKING_MODE  = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MSB_FIRST     = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_SAMPLES   = 8'd3;

    // sample_format codes
    localparam logic [1:0] FMT_10 = 2'd0;
    localparam logic [1:0] FMT_12 = 2'd1;
    localparam logic [1:0] FMT_16 = 2'd2;

    // packing_mode codes
    localparam logic [1:0] PM_PACKED = 2'd0;
    localparam logic [1:0] PM_PAD_R  = 2'd1;
    localparam logic [1:0] PM_PAD_L  = 2'd2;

    // how the back end walks a word
    typedef enum logic [2:0] {
        K_NONE,
        K_PACK10,
        K_PACK12,
        K_FILL_R,
        K_FILL_L,
        K_HALVES
    } t_kind;

    // queued word: packed/filled words are in file bit order,
    // halves words already hold both finished codes {first, second}
    typedef struct packed {
        logic [WORD_W-1:0] data;
        t_kind             kind;
        logic              frame;
    } t_item;

    typedef struct packed {
        logic [ROW_W-1:0] row_len;
        logic             clear;
    } t_ctl;

endpackage

`default_nettype wire

>>> sv/packed_sample_unpacker_core.sv
// A beat is registered in the queue, and its samples are registered in the output register.
// Throughput: one sample per cycle while the output is not stalled; a word
// yields 1 to 4 samples, or none if the settings select no samples.
// A two-entry queue lets the input take beats while the output is stalled.
// Reset (i_rst_n low, synchronous): registers to their defaults, carry and
// row position cleared, queue and output emptied.
// ----------------------------------------------------------------------------
// packed_sample_unpacker_core
// Unpacks 10/12/16-bit image samples from 32-bit file words.
// ----------------------------------------------------------------------------
`default_nettype none

module packed_sample_unpacker_core #(
    parameter int MAX_ROW_SAMPLES = psu_pkg::MAX_ROW_SAMPLES_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // configuration write channel
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [psu_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [psu_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // word input
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    input  wire logic [31:0]                    s_axis_tdata,  // [31:0] data_word
    input  wire logic [0:0]                     s_axis_tuser,  // [0] frame_start
    // sample output
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    output logic [15:0]                         m_axis_tdata,  // [15:0] sample_code
    output logic [0:0]                          m_axis_tuser,  // [0] row_end
    output logic                                m_axis_tlast
);
    import psu_pkg::*;

    t_item q_in, q_out;
    t_ctl  ctl;
    logic  q_full, q_valid, q_pop;

    psu_front #(
        .MAX_ROW_SAMPLES (MAX_ROW_SAMPLES)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_word      (s_axis_tdata),
        .i_frame     (s_axis_tuser[0]),
        .o_item      (q_in),
        .o_ctl       (ctl)
    );

    assign s_axis_tready = !q_full;

    psu_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (s_axis_tvalid),
        .i_item  (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_item  (q_out),
        .o_valid (q_valid)
    );

    psu_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctl         (ctl),
        .i_item        (q_out),
        .i_item_valid  (q_valid),
        .o_item_ready  (q_pop),
        .o_valid       (m_axis_tvalid),
        .i_ready       (m_axis_tready),
        .o_sample_code (m_axis_tdata),
        .o_row_end     (m_axis_tuser[0]),
        .o_last        (m_axis_tlast)
    );

endmodule

`default_nettype wire

>>> sv/psu_front.sv
// ----------------------------------------------------------------------------
// psu_front
// Configuration registers and classification of incoming words.
// ----------------------------------------------------------------------------
`default_nettype none

module psu_front #(
    parameter int MAX_ROW_SAMPLES = psu_pkg::MAX_ROW_SAMPLES_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [psu_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [psu_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  wire logic [psu_pkg::WORD_W-1:0]        i_word,
    input  wire logic                              i_frame,
    output psu_pkg::t_item                         o_item,
    output psu_pkg::t_ctl                          o_ctl
);
    import psu_pkg::*;

    localparam int ROW_CAP = (1 << ROW_W) - 1;
    localparam logic [ROW_W-1:0] ROW_MAX =
        (MAX_ROW_SAMPLES > ROW_CAP) ? ROW_W'(ROW_CAP) : ROW_W'(MAX_ROW_SAMPLES);

    logic [1:0]       r_fmt, n_fmt;
    logic [1:0]       r_pm, n_pm;
    logic             r_msb, n_msb;
    logic [ROW_W-1:0] r_row_samples, n_row_samples;
    logic             cfg_hit;

    t_kind             kind;
    logic [WORD_W-1:0] v;
    logic [15:0]       h0, h1;

    function automatic logic [15:0] half_code(input logic [15:0] h,
                                              input logic [1:0]  fmt,
                                              input logic [1:0]  pm);
        logic [15:0] c;
        if (fmt == FMT_16) begin
            c = h;
        end else if (pm == PM_PAD_R) begin
            c = {4'd0, h[15:4]};
        end else begin
            c = {4'd0, h[11:0]};
        end
        return c;
    endfunction

    assign o_cfg_ready = 1'b1;

    always_comb begin
        n_fmt         = r_fmt;
        n_pm          = r_pm;
        n_msb         = r_msb;
        n_row_samples = r_row_samples;
        cfg_hit       = 1'b0;
        if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_SAMPLE_FORMAT: begin
                    n_fmt   = i_cfg_data[1:0];
                    cfg_hit = 1'b1;
                end
                REG_PACKING_MODE: begin
                    n_pm    = i_cfg_data[1:0];
                    cfg_hit = 1'b1;
                end
                REG_MSB_FIRST: begin
                    n_msb   = i_cfg_data[0];
                    cfg_hit = 1'b1;
                end
                REG_ROW_SAMPLES: begin
                    n_row_samples = i_cfg_data[ROW_W-1:0];
                    cfg_hit       = 1'b1;
                end
                default: begin
                    cfg_hit = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fmt         <= FMT_10;
            r_pm          <= PM_PAD_R;
            r_msb         <= 1'b1;
            r_row_samples <= ROW_W'(1);
        end else begin
            r_fmt         <= n_fmt;
            r_pm          <= n_pm;
            r_msb         <= n_msb;
            r_row_samples <= n_row_samples;
        end
    end

    // stream state restarts on every listed register write
    always_comb begin
        o_ctl.clear = cfg_hit;
        if (r_row_samples == '0) begin
            o_ctl.row_len = ROW_W'(1);
        end else if (r_row_samples > ROW_MAX) begin
            o_ctl.row_len = ROW_MAX;
        end else begin
            o_ctl.row_len = r_row_samples;
        end
    end

    always_comb begin
        case (r_fmt)
            FMT_10: begin
                case (r_pm)
                    PM_PACKED: kind = K_PACK10;
                    PM_PAD_R:  kind = K_FILL_R;
                    PM_PAD_L:  kind = K_FILL_L;
                    default:   kind = K_NONE;
                endcase
            end
            FMT_12: begin
                case (r_pm)
                    PM_PACKED: kind = K_PACK12;
                    PM_PAD_R:  kind = K_HALVES;
                    PM_PAD_L:  kind = K_HALVES;
                    default:   kind = K_NONE;
                endcase
            end
            FMT_16:  kind = K_HALVES;
            default: kind = K_NONE;
        endcase
    end

    always_comb begin
        if (r_msb) begin
            v  = i_word;
            h0 = i_word[31:16];
            h1 = i_word[15:0];
        end else begin
            v  = {i_word[7:0], i_word[15:8], i_word[23:16], i_word[31:24]};
            h0 = {i_word[23:16], i_word[31:24]};
            h1 = {i_word[7:0], i_word[15:8]};
        end
    end

    always_comb begin
        o_item.kind  = kind;
        o_item.frame = i_frame;
        if (kind == K_HALVES) begin
            o_item.data = {half_code(h0, r_fmt, r_pm), half_code(h1, r_fmt, r_pm)};
        end else begin
            o_item.data = v;
        end
    end

endmodule

`default_nettype wire

>>> sv/psu_queue.sv
// ----------------------------------------------------------------------------
// psu_queue
// Small flop FIFO between the classifying front and the sample back end.
// ----------------------------------------------------------------------------
`default_nettype none

module psu_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire psu_pkg::t_item i_item,
    output logic                o_full,
    input  wire logic           i_pop,
    output psu_pkg::t_item      o_item,
    output logic                o_valid
);
    import psu_pkg::*;

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    t_item         r_mem [QUEUE_DEPTH];
    logic [AW-1:0] r_wr_ptr, n_wr_ptr;
    logic [AW-1:0] r_rd_ptr, n_rd_ptr;
    logic [AW:0]   r_count, n_count;
    logic          do_push, do_pop;

    assign o_full  = (r_count == (AW+1)'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];

    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == AW'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + AW'(1);
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == AW'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + AW'(1);
        end
        if (do_push && !do_pop) begin
            n_count = r_count + (AW+1)'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - (AW+1)'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

`default_nettype wire

>>> sv/psu_back.sv
// ----------------------------------------------------------------------------
// psu_back
// Walks one queued word, one sample per cycle while the output is not stalled, keeping carry and row state.
// ----------------------------------------------------------------------------
`default_nettype none
`include "packed_sample_unpacker_core_defines.svh"

module psu_back (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire psu_pkg::t_ctl              i_ctl,
    input  wire psu_pkg::t_item             i_item,
    input  wire logic                       i_item_valid,
    output logic                            o_item_ready,
    output logic                            o_valid,
    input  wire logic                       i_ready,
    output logic [psu_pkg::CODE_W-1:0]      o_sample_code,
    output logic                            o_row_end,
    output logic                            o_last
);
    import psu_pkg::*;

    // word walk state
    logic              r_busy, n_busy;
    t_kind             r_kind, n_kind;
    logic [WORD_W-1:0] r_data, n_data;
    logic [5:0]        r_bitpos, n_bitpos;
    logic [1:0]        r_k, n_k;
    // stream state
    logic [11:0]       r_carry, n_carry;
    logic [3:0]        r_clen, n_clen;
    logic [ROW_W-1:0]  r_row_pos, n_row_pos;
    // output register
    logic              r_ov, n_ov;
    logic [CODE_W-1:0] r_code, n_code;
    logic              r_row_end, n_row_end;
    logic              r_last, n_last;

    logic              fresh, frame, have, out_free, emit, pop, is_packed, drop;
    t_kind             kind_e;
    logic [WORD_W-1:0] data_e;
    logic [ROW_W-1:0]  rowpos_e;
    logic [11:0]       carry_e;
    logic [3:0]        clen_e;
    logic [5:0]        bitpos_e;
    logic [1:0]        k_e;
    logic [3:0]        d;
    logic [11:0]       mask;
    logic              ended;
    logic [3:0]        need;
    logic [11:0]       lowmask, shifted, code_carry, code_seq, code_pk;
    logic [5:0]        nbit;
    logic              last_pk, keep_carry;
    logic [4:0]        fill_shift;
    logic [9:0]        code_fill;
    logic [CODE_W-1:0] code;
    logic              last;
    logic              busy_halves, busy_fill, stream_idle;

    assign fresh    = !r_busy;
    assign kind_e   = fresh ? i_item.kind : r_kind;
    assign data_e   = fresh ? i_item.data : r_data;
    assign frame    = fresh && i_item.frame;
    assign have     = fresh ? i_item_valid : 1'b1;
    assign out_free = !r_ov || i_ready;

    assign is_packed = kind_e inside {K_PACK10, K_PACK12};
    assign d         = (kind_e == K_PACK12) ? 4'd12 : 4'd10;
    assign mask      = (kind_e == K_PACK12) ? 12'hfff : 12'h3ff;

    // a carry at least a sample long is stale and dropped
    assign drop     = frame || (fresh && is_packed && (r_clen >= d));
    assign rowpos_e = frame ? '0 : r_row_pos;
    assign carry_e  = drop ? '0 : r_carry;
    assign clen_e   = drop ? '0 : r_clen;
    assign bitpos_e = fresh ? '0 : r_bitpos;
    assign k_e      = fresh ? '0 : r_k;

    assign ended = ({1'b0, rowpos_e} + (ROW_W+1)'(1)) >= {1'b0, i_ctl.row_len};

    // packed: finish a split sample first, then step through the word
    assign need       = d - clen_e;
    assign lowmask    = 12'((13'd1 << need) - 13'd1);
    assign shifted    = (data_e[11:0] & lowmask) << clen_e;
    assign code_carry = (carry_e | shifted) & mask;
    assign code_seq   = 12'(data_e >> bitpos_e) & mask;

    always_comb begin
        if (clen_e != '0) begin
            code_pk = code_carry;
            nbit    = {2'b00, need};
        end else begin
            code_pk = code_seq;
            nbit    = bitpos_e + {2'b00, d};
        end
    end

    assign last_pk    = ended || (({1'b0, nbit} + {3'b000, d}) > 7'd32);
    assign keep_carry = !ended && (nbit < 6'd32);

    // filled: first sample sits highest
    always_comb begin
        case (k_e)
            2'd0:    fill_shift = (kind_e == K_FILL_R) ? 5'd22 : 5'd20;
            2'd1:    fill_shift = (kind_e == K_FILL_R) ? 5'd12 : 5'd10;
            default: fill_shift = (kind_e == K_FILL_R) ? 5'd2  : 5'd0;
        endcase
    end
    assign code_fill = 10'(data_e >> fill_shift);

    always_comb begin
        case (kind_e)
            K_PACK10, K_PACK12: begin
                code = {4'd0, code_pk};
                last = last_pk;
            end
            K_FILL_R, K_FILL_L: begin
                code = {6'd0, code_fill};
                last = ended || (k_e == 2'd2);
            end
            K_HALVES: begin
                code = (k_e == 2'd0) ? data_e[31:16] : data_e[15:0];
                last = (k_e != 2'd0);
            end
            default: begin
                code = '0;
                last = 1'b1;
            end
        endcase
    end

    assign emit         = have && (kind_e != K_NONE) && out_free;
    assign o_item_ready = fresh && ((i_item.kind == K_NONE) || out_free);
    assign pop          = o_item_ready && i_item_valid;

    always_comb begin
        n_busy    = r_busy;
        n_kind    = r_kind;
        n_data    = r_data;
        n_bitpos  = r_bitpos;
        n_k       = r_k;
        n_carry   = r_carry;
        n_clen    = r_clen;
        n_row_pos = r_row_pos;
        n_ov      = r_ov && !i_ready;
        n_code    = r_code;
        n_row_end = r_row_end;
        n_last    = r_last;

        if (i_ctl.clear) begin
            n_busy    = 1'b0;
            n_carry   = '0;
            n_clen    = '0;
            n_row_pos = '0;
        end else if (emit) begin
            n_ov      = 1'b1;
            n_code    = code;
            n_row_end = ended;
            n_last    = last;
            n_row_pos = ended ? '0 : rowpos_e + ROW_W'(1);
            n_busy    = !last;
            n_kind    = kind_e;
            n_data    = data_e;
            n_k       = k_e + 2'd1;
            n_bitpos  = nbit;
            if (is_packed) begin
                n_carry = (last && keep_carry) ? 12'(data_e >> nbit) : '0;
                n_clen  = (last && keep_carry) ? 4'(6'd32 - nbit) : '0;
            end else begin
                n_carry = carry_e;
                n_clen  = clen_e;
            end
        end else if (pop) begin
            // word with no samples: only the frame clear applies
            n_row_pos = rowpos_e;
            n_carry   = carry_e;
            n_clen    = clen_e;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_kind    <= K_NONE;
            r_bitpos  <= '0;
            r_k       <= '0;
            r_carry   <= '0;
            r_clen    <= '0;
            r_row_pos <= '0;
            r_ov      <= 1'b0;
        end else begin
            r_busy    <= n_busy;
            r_kind    <= n_kind;
            r_bitpos  <= n_bitpos;
            r_k       <= n_k;
            r_carry   <= n_carry;
            r_clen    <= n_clen;
            r_row_pos <= n_row_pos;
            r_ov      <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data    <= n_data;
        r_code    <= n_code;
        r_row_end <= n_row_end;
        r_last    <= n_last;
    end

    assign o_valid       = r_ov;
    assign o_sample_code = r_code;
    assign o_row_end     = r_row_end;
    assign o_last        = r_last;

    assign busy_halves = r_busy && (r_kind == K_HALVES);
    assign busy_fill   = r_busy && (r_kind inside {K_FILL_R, K_FILL_L});
    assign stream_idle = (r_row_pos == '0) && (r_clen == '0) && !r_busy;

    `PSU_ASSERT(a_clen_short, i_clk, i_rst_n, r_clen < 4'd12)
    `PSU_ASSERT(a_busy_kind, i_clk, i_rst_n, r_busy |-> (r_kind != K_NONE))
    `PSU_ASSERT(a_halves_second, i_clk, i_rst_n, busy_halves |-> (r_k == 2'd1))
    `PSU_ASSERT(a_fill_slot, i_clk, i_rst_n, busy_fill |-> (r_k == 2'd1 || r_k == 2'd2))
    `PSU_ASSERT(a_clear_stream, i_clk, i_rst_n, i_ctl.clear |=> stream_idle)

endmodule

`default_nettype wire

>>> tb/psu_sample_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psu_sample_checker
// Watches the register, word and sample channels of the unpacker. It tracks
// the register settings, carry and row position itself, works out the samples
// each accepted word should give, and compares every sample beat in order.
// ----------------------------------------------------------------------------

module psu_sample_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    input  logic                           i_cfg_ready,
    input  logic [psu_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [psu_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_word_valid,
    input  logic                           i_word_ready,
    input  logic [31:0]                    i_word_data,
    input  logic [0:0]                     i_word_user,
    input  logic                           i_sample_valid,
    input  logic                           i_sample_ready,
    input  logic [15:0]                    i_sample_data,
    input  logic [0:0]                     i_sample_user,
    input  logic                           i_sample_last,
    output int                             o_pending,
    output int                             o_mismatches
);
    import psu_pkg::*;

    typedef struct packed {
        logic [15:0] code;
        logic        row_end;
        logic        last;
    } t_sample;

    t_sample expected_samples[$];
    t_sample want;
    t_sample got;
    int      mismatch_count = 0;

    // register copies
    logic [1:0]  cfg_format;
    logic [1:0]  cfg_packing;
    logic        cfg_msb;
    logic [15:0] cfg_rows;

    // stream state
    logic [11:0] carry_bits;
    logic [3:0]  carry_len;
    logic [15:0] row_pos;

    assign o_mismatches = mismatch_count;

    function automatic void drop_stream();
        carry_bits = '0;
        carry_len  = '0;
        row_pos    = '0;
    endfunction

    // one sample advances the row; row length is clamped to 1..max
    function automatic t_sample row_step(input logic [15:0] code);
        t_sample     s;
        int unsigned lim;
        lim = cfg_rows;
        if (lim < 1) lim = 1;
        if (lim > MAX_ROW_SAMPLES_DEF) lim = MAX_ROW_SAMPLES_DEF;
        s.code    = code;
        s.row_end = ({16'd0, row_pos} + 32'd1 >= lim);
        s.last    = 1'b0;
        row_pos   = s.row_end ? 16'd0 : row_pos + 16'd1;
        return s;
    endfunction

    task automatic unpack_word(input logic [31:0] w, input logic frame_start);
        t_sample     batch[4];
        int          n;
        int          k;
        logic [31:0] v;
        logic [31:0] mask;
        logic [31:0] t;
        logic [15:0] h0;
        logic [15:0] h1;
        logic [15:0] h;
        int unsigned d;
        int unsigned pos;
        int unsigned need;
        int unsigned shift;
        logic        ended;

        n     = 0;
        ended = 1'b0;
        v     = cfg_msb ? w : {w[7:0], w[15:8], w[23:16], w[31:24]};
        if (frame_start) drop_stream();

        if (cfg_format <= FMT_12 && cfg_packing == PM_PACKED) begin
            d    = (cfg_format == FMT_12) ? 12 : 10;
            mask = (32'd1 << d) - 32'd1;
            pos  = 0;
            if (carry_len >= d) begin
                carry_bits = '0;
                carry_len  = '0;
            end
            // finish the sample split over the word boundary
            if (carry_len != 0) begin
                need = d - carry_len;
                t = ({20'd0, carry_bits} | ((v & ((32'd1 << need) - 32'd1)) << carry_len))
                    & mask;
                carry_bits = '0;
                carry_len  = '0;
                pos        = need;
                batch[n]   = row_step(t[15:0]);
                ended      = batch[n].row_end;
                n++;
            end
            while (!ended && pos + d <= 32) begin
                t        = (v >> pos) & mask;
                pos      = pos + d;
                batch[n] = row_step(t[15:0]);
                ended    = batch[n].row_end;
                n++;
            end
            if (!ended && pos < 32) begin
                t          = v >> pos;
                carry_bits = t[11:0];
                carry_len  = 4'(32 - pos);
            end
        end else if (cfg_format == FMT_10 &&
                     (cfg_packing == PM_PAD_R || cfg_packing == PM_PAD_L)) begin
            shift = (cfg_packing == PM_PAD_R) ? 22 : 20;
            for (k = 0; k < 3; k++) begin
                if (!ended) begin
                    t        = (v >> shift) & 32'h3ff;
                    batch[n] = row_step(t[15:0]);
                    ended    = batch[n].row_end;
                    n++;
                    shift    = shift - 10;
                end
            end
        end else if ((cfg_format == FMT_12 &&
                      (cfg_packing == PM_PAD_R || cfg_packing == PM_PAD_L)) ||
                     cfg_format == FMT_16) begin
            // halves take file byte order, no row padding
            if (cfg_msb) begin
                h0 = w[31:16];
                h1 = w[15:0];
            end else begin
                h0 = {w[23:16], w[31:24]};
                h1 = {w[7:0], w[15:8]};
            end
            for (k = 0; k < 2; k++) begin
                h = (k == 0) ? h0 : h1;
                if (cfg_format == FMT_16)
                    batch[n] = row_step(h);
                else if (cfg_packing == PM_PAD_R)
                    batch[n] = row_step({4'd0, h[15:4]});
                else
                    batch[n] = row_step({4'd0, h[11:0]});
                n++;
            end
        end

        for (k = 0; k < n; k++) begin
            if (k == n - 1) batch[k].last = 1'b1;
            expected_samples.push_back(batch[k]);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg_format  = FMT_10;
            cfg_packing = PM_PAD_R;
            cfg_msb     = 1'b1;
            cfg_rows    = 16'd1;
            drop_stream();
            expected_samples.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_SAMPLE_FORMAT: begin
                        cfg_format = i_cfg_data[1:0];
                        drop_stream();
                    end
                    REG_PACKING_MODE: begin
                        cfg_packing = i_cfg_data[1:0];
                        drop_stream();
                    end
                    REG_MSB_FIRST: begin
                        cfg_msb = i_cfg_data[0];
                        drop_stream();
                    end
                    REG_ROW_SAMPLES: begin
                        cfg_rows = i_cfg_data[15:0];
                        drop_stream();
                    end
                    default: ;
                endcase
            end

            if (i_word_valid && i_word_ready)
                unpack_word(i_word_data, i_word_user[0]);

            if (i_sample_valid && i_sample_ready) begin
                got.code    = i_sample_data;
                got.row_end = i_sample_user[0];
                got.last    = i_sample_last;
                if (expected_samples.size() == 0) begin
                    $display("%0t: unexpected sample, got code %h row_end %b last %b",
                             $time, got.code, got.row_end, got.last);
                    mismatch_count++;
                end else begin
                    want = expected_samples.pop_front();
                    if (got !== want) begin
                        $display("%0t: exp code %h row_end %b last %b, got %h %b %b",
                                 $time, want.code, want.row_end, want.last,
                                 got.code, got.row_end, got.last);
                        mismatch_count++;
                    end
                end
            end
        end
        o_pending <= expected_samples.size();
    end

endmodule

>>> tb/packed_sample_unpacker_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// packed_sample_unpacker_core_tb
// Drives register settings and file words into the unpacker: a directed pass
// over every format, packing mode, byte order and row-length extreme, then
// random settings with random word streams, random idle cycles on both sides
// and one long output stall. The checker instance predicts and compares.
// ----------------------------------------------------------------------------

module packed_sample_unpacker_core_tb;
    import psu_pkg::*;

    localparam int CLK_PERIOD    = 20;
    localparam int RESET_CYCLES  = 9;
    localparam int IDLE_PCT      = 9;
    localparam int HOLD_CYCLES   = 80;
    localparam int SETTLE_CYCLES = 8;
    localparam int TAIL_CYCLES   = 20;
    localparam int RANDOM_WORDS  = 285;
    localparam int WATCHDOG_NS   = 4_000_000;

    // selector values the block does not use
    localparam logic [1:0]           FMT_UNUSED   = 2'd3;
    localparam logic [1:0]           PM_UNUSED    = 2'd3;
    localparam logic [CFG_IDX_W-1:0] REG_UNLISTED = 8'd7;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [31:0]           s_axis_tdata;
    logic [0:0]            s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [15:0]           m_axis_tdata;
    logic [0:0]            m_axis_tuser;
    logic                  m_axis_tlast;

    int   pending;
    int   mismatches;
    logic no_idle  = 1'b0;
    logic hold_req = 1'b0;

    packed_sample_unpacker_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    psu_sample_checker checker_i (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_word_valid   (s_axis_tvalid),
        .i_word_ready   (s_axis_tready),
        .i_word_data    (s_axis_tdata),
        .i_word_user    (s_axis_tuser),
        .i_sample_valid (m_axis_tvalid),
        .i_sample_ready (m_axis_tready),
        .i_sample_data  (m_axis_tdata),
        .i_sample_user  (m_axis_tuser),
        .i_sample_last  (m_axis_tlast),
        .o_pending      (pending),
        .o_mismatches   (mismatches)
    );

    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    initial begin
        #(WATCHDOG_NS);
        $display("packed_sample_unpacker_core: mismatch");
        $finish;
    end

    // sample sink: random back-pressure, one long hold-off on request
    initial begin
        logic hold_done;
        hold_done     = 1'b0;
        m_axis_tready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req && !hold_done) begin
                hold_done = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            m_axis_tready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    task automatic cfg_beat(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
    endtask

    task automatic write_setting(input logic [1:0] fmt, input logic [1:0] pm,
                                 input logic msb, input logic [15:0] rows);
        cfg_beat(REG_SAMPLE_FORMAT, {14'd0, fmt});
        cfg_beat(REG_PACKING_MODE, {14'd0, pm});
        cfg_beat(REG_MSB_FIRST, {15'd0, msb});
        cfg_beat(REG_ROW_SAMPLES, rows);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic send_word(input logic [31:0] w, input logic frame_start);
        while (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= w;
        s_axis_tuser  <= frame_start;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    // drain, then allow for a word with no samples still in the back end
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        int          phase;
        int          counted;
        int          n_words;
        int          i;
        logic [1:0]  fmt;
        logic [1:0]  pm;
        logic        msb;
        logic [15:0] rows;
        logic        silent;
        logic [31:0] word;
        logic        frame_start;

        i_rst_n       = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = '0;
        i_cfg_data    = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: ten-bit filled, padded right, one-sample rows
        send_word(32'hFFFF_FFFF, 1'b1);
        send_word(32'h0000_0000, 1'b0);
        settle();

        write_setting(FMT_10, PM_PACKED, 1'b1, 16'd5);
        send_word(32'hFFFF_FFFF, 1'b1);
        send_word(32'hAAAA_AAAA, 1'b0);
        send_word(32'h5555_5555, 1'b0);
        send_word(32'h1234_5678, 1'b1);
        settle();

        // zero row length clamps to one
        write_setting(FMT_12, PM_PACKED, 1'b0, 16'd0);
        send_word(32'h89AB_CDEF, 1'b1);
        send_word(32'hFFFF_FFFF, 1'b0);
        send_word(32'h0000_0000, 1'b0);
        settle();

        write_setting(FMT_10, PM_PAD_L, 1'b0, 16'd4);
        send_word(32'h3FF0_03FF, 1'b1);
        send_word(32'h8000_0001, 1'b0);
        settle();

        write_setting(FMT_12, PM_PAD_R, 1'b1, 16'd3);
        send_word(32'hFFF0_000F, 1'b1);
        send_word(32'h0123_ABCD, 1'b0);
        settle();

        write_setting(FMT_12, PM_PAD_L, 1'b0, 16'd2);
        send_word(32'hFEDC_BA98, 1'b1);
        send_word(32'h7FFF_8000, 1'b0);
        settle();

        // sixteen-bit ignores packing mode; oversize row clamps to max
        write_setting(FMT_16, PM_UNUSED, 1'b1, 16'hFFFF);
        send_word(32'hFFFF_0000, 1'b1);
        send_word(32'h0000_FFFF, 1'b0);
        settle();

        write_setting(FMT_UNUSED, PM_PACKED, 1'b1, 16'd9);
        send_word(32'hFFFF_FFFF, 1'b1);
        send_word(32'h0000_0000, 1'b0);
        settle();

        write_setting(FMT_10, PM_UNUSED, 1'b0, 16'd9);
        send_word(32'h5A5A_5A5A, 1'b0);
        settle();

        // write to an unlisted index must keep the carry
        write_setting(FMT_12, PM_PACKED, 1'b1, 16'd32768);
        send_word(32'hDEAD_BEEF, 1'b1);
        send_word(32'h0F0F_0F0F, 1'b0);
        settle();
        cfg_beat(REG_UNLISTED, 16'hFFFF);
        i_cfg_valid <= 1'b0;
        send_word(32'h7654_3210, 1'b0);
        send_word(32'hFFFF_FFFF, 1'b0);
        settle();

        phase   = 0;
        counted = 0;
        while (counted < RANDOM_WORDS) begin
            case ($urandom_range(0, 19))
                0, 1, 2, 3, 4, 5:         fmt = FMT_10;
                6, 7, 8, 9, 10, 11:       fmt = FMT_12;
                12, 13, 14, 15, 16, 17:   fmt = FMT_16;
                default:                  fmt = FMT_UNUSED;
            endcase
            case ($urandom_range(0, 19))
                0, 1, 2, 3, 4, 5, 6:      pm = PM_PACKED;
                7, 8, 9, 10, 11, 12:      pm = PM_PAD_R;
                13, 14, 15, 16, 17:       pm = PM_PAD_L;
                default:                  pm = PM_UNUSED;
            endcase
            msb = 1'($urandom_range(0, 1));
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: rows = 16'($urandom_range(1, 12));
                5, 6:          rows = 16'($urandom_range(13, 300));
                7:             rows = 16'd0;
                8:             rows = 16'd32768;
                default:       rows = 16'($urandom_range(0, 65535));
            endcase
            silent  = (fmt == FMT_UNUSED) || (fmt != FMT_16 && pm == PM_UNUSED);
            n_words = silent ? 4 : $urandom_range(15, 35);
            no_idle = (phase == 5 || phase == 6);

            write_setting(fmt, pm, msb, rows);
            for (i = 0; i < n_words; i++) begin
                if (!silent && i == 2) hold_req = 1'b1;
                case ($urandom_range(0, 9))
                    0:       word = 32'hFFFF_FFFF;
                    1:       word = 32'h0000_0000;
                    default: word = $urandom;
                endcase
                if (i == 0)
                    frame_start = 1'($urandom_range(0, 1));
                else
                    frame_start = ($urandom_range(0, 99) < 6);
                send_word(word, frame_start);
                if (!silent) counted++;
            end
            settle();
            phase++;
        end

        no_idle = 1'b0;
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0)
            $display("packed_sample_unpacker_core: match");
        else
            $display("packed_sample_unpacker_core: mismatch");
        $finish;
    end

endmodule

>>> sim.f
+incdir+sv
sv/psu_pkg.sv
sv/psu_front.sv
sv/psu_queue.sv
sv/psu_back.sv
sv/packed_sample_unpacker_core.sv
tb/psu_sample_checker.sv
tb/packed_sample_unpacker_core_tb.sv
